// ===== design/cdcs_pkg.sv =====
// ---------------------------------------------------------------------------
// cdcs_pkg
// Shared types and constants for the distinct-count sampler.
// ---------------------------------------------------------------------------
`default_nettype none

package cdcs_pkg;

    localparam int unsigned BUFFER_ENTRIES_DEF = 64;
    localparam int unsigned PORT_BASE_DEF      = 8000;
    localparam int unsigned PORT_LIMIT_DEF     = 8128;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned PRIO_W  = 32;
    localparam int unsigned PORT_W  = 16;
    localparam int unsigned HELD_W  = 7;
    localparam int unsigned THR_W   = 32;

    // Input tdata: dest_port, packet_key, random_fraction
    localparam int unsigned IN_TDATA_W  = 80;
    // Output tdata: verdict, key_kept, held_count, current_threshold (+ pad)
    localparam int unsigned OUT_TDATA_W = 48;

    localparam logic [THR_W-1:0] START_THRESHOLD_RST = '1;

    // Flags carried by the scan beat as it walks down the cell row
    typedef struct packed {
        logic active;      // scan beat present at this point of the row
        logic removed;     // a cell upstream held the key and dropped it
        logic free_found;  // a free slot upstream (lowest one kept)
        logic top_found;   // a live entry upstream (highest priority kept)
    } wave_flags_t;

    // Broadcast write controls from the sequencer to every cell
    typedef struct packed {
        logic wr_en;       // write key/priority into the addressed slot
        logic clear;       // drop every entry
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/cvm_distinct_count_sampler_top.sv =====
// ---------------------------------------------------------------------------
// cvm_distinct_count_sampler_top
// Priority-form CVM distinct-count sampler over a row of store cells.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis: one beat per packet. tuser = length_ok. tdata = dest_port [15:0],
//     packet_key [47:16], random_fraction [79:48].
//   m_axis: one beat per input beat. tdata = verdict [0], key_kept [1],
//     held_count [8:2], current_threshold [40:9], zeros above.
//   cfg_we/cfg_wdata: writes start_threshold, empties the store and loads
//     the threshold. Write only while no beat is in flight.
// Timing:
//   One packet at a time: a new packet is accepted only in idle, once the
//   previous one has reached the result register. A passed packet (short,
//   or port outside the sampled range) goes from check straight to emit. A
//   sampled packet walks the cell row one cell per cycle, then decide, then
//   emit; the cell count bounds throughput.
// Reset:
//   Store empty, count zero, threshold all ones.
// Backpressure:
//   The result sits in an output register; the next packet is accepted
//   while it waits, and the block holds its next result until m_axis_tready.
//   Software estimates distinct count as held_count / (threshold / 2^32).
// ---------------------------------------------------------------------------
`default_nettype none

module cvm_distinct_count_sampler_top #(
    parameter int unsigned BUFFER_ENTRIES = cdcs_pkg::BUFFER_ENTRIES_DEF,
    parameter int unsigned PORT_BASE      = cdcs_pkg::PORT_BASE_DEF,
    parameter int unsigned PORT_LIMIT     = cdcs_pkg::PORT_LIMIT_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    // config
    input  wire                                cfg_we,
    input  wire  [cdcs_pkg::THR_W-1:0]         cfg_wdata,   // start_threshold
    // packet in
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [cdcs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // port, key, fraction
    input  wire                                s_axis_tuser,  // length_ok
    // result out
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [cdcs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // verdict, kept, count, thr
);
    import cdcs_pkg::*;

    localparam int unsigned IDX_W = $clog2(BUFFER_ENTRIES);
    localparam int unsigned CNT_W = $clog2(BUFFER_ENTRIES + 1);
    localparam int unsigned PCMP_W = PORT_W + 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // captured packet
    logic              len_ok_reg;
    logic [PORT_W-1:0] port_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [PRIO_W-1:0] frac_reg;

    // estimator state
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [THR_W-1:0]  thr_reg, thr_next;

    // scan result
    logic              scan_removed_reg;
    logic              scan_free_found_reg;
    logic              scan_top_found_reg;
    logic [IDX_W-1:0]  scan_free_idx_reg;
    logic [IDX_W-1:0]  scan_top_idx_reg;
    logic [PRIO_W-1:0] scan_top_prio_reg;

    // pending result and output register
    logic              res_verdict_reg, res_verdict_next;
    logic              res_kept_reg, res_kept_next;
    logic              out_valid_reg;
    logic              out_verdict_reg;
    logic              out_kept_reg;
    logic [HELD_W-1:0] out_held_reg;
    logic [THR_W-1:0]  out_thr_reg;

    // cell row
    wave_flags_t       wave [BUFFER_ENTRIES+1];
    logic [IDX_W-1:0]  free_idx [BUFFER_ENTRIES+1];
    logic [IDX_W-1:0]  top_idx [BUFFER_ENTRIES+1];
    logic [PRIO_W-1:0] top_prio [BUFFER_ENTRIES+1];

    cell_ctl_t         ctl;
    logic [IDX_W-1:0]  wr_idx;

    logic              in_accept;
    logic              in_range;
    logic              out_take;
    logic [CNT_W-1:0]  count_after;
    wave_flags_t       last_wave;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_take = !out_valid_reg || m_axis_tready;

    assign in_range = len_ok_reg
                   && ({1'b0, port_reg} >= PCMP_W'(PORT_BASE))
                   && ({1'b0, port_reg} <  PCMP_W'(PORT_LIMIT));

    // launch the scan beat into the head of the row
    always_comb
    begin
        wave[0]        = '0;
        wave[0].active = (state_reg == ST_CHECK) && in_range;
        free_idx[0]    = '0;
        top_idx[0]     = '0;
        top_prio[0]    = '0;
    end

    assign last_wave = wave[BUFFER_ENTRIES];

    genvar g;
    generate
        for (g = 0; g < BUFFER_ENTRIES; g++)
        begin : g_cell
            cdcs_cell #(
                .IDX_W (IDX_W),
                .INDEX (g)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .wave_in      (wave[g]),
                .free_idx_in  (free_idx[g]),
                .top_idx_in   (top_idx[g]),
                .top_prio_in  (top_prio[g]),
                .item_key     (key_reg),
                .ctl          (ctl),
                .wr_idx       (wr_idx),
                .wr_key       (key_reg),
                .wr_prio      (frac_reg),
                .wave_out     (wave[g+1]),
                .free_idx_out (free_idx[g+1]),
                .top_idx_out  (top_idx[g+1]),
                .top_prio_out (top_prio[g+1])
            );
        end
    endgenerate

    assign count_after = count_reg - CNT_W'(scan_removed_reg);

    // config write, passed verdict, and sampling decision once the scan is back
    always_comb
    begin
        ctl.clear        = cfg_we;
        ctl.wr_en        = 1'b0;
        wr_idx           = scan_free_idx_reg;
        count_next       = count_reg;
        thr_next         = thr_reg;
        res_verdict_next = res_verdict_reg;
        res_kept_next    = res_kept_reg;
        if (cfg_we)
        begin
            count_next = '0;
            thr_next   = cfg_wdata;
        end
        else if (state_reg == ST_CHECK && !in_range)
        begin
            res_verdict_next = 1'b0;
            res_kept_next    = 1'b0;
        end
        else if (state_reg == ST_DECIDE)
        begin
            res_verdict_next = 1'b1;
            res_kept_next    = 1'b0;
            count_next       = count_after;
            if (frac_reg <= thr_reg)
            begin
                if (count_after < CNT_W'(BUFFER_ENTRIES))
                begin
                    if (scan_free_found_reg)
                    begin
                        ctl.wr_en     = 1'b1;
                        wr_idx        = scan_free_idx_reg;
                        count_next    = count_after + CNT_W'(1);
                        res_kept_next = 1'b1;
                    end
                end
                else if (scan_top_found_reg)
                begin
                    if (frac_reg > scan_top_prio_reg)
                    begin
                        thr_next = frac_reg;
                    end
                    else
                    begin
                        // evict the top entry, threshold drops to its priority
                        thr_next      = scan_top_prio_reg;
                        ctl.wr_en     = 1'b1;
                        wr_idx        = scan_top_idx_reg;
                        res_kept_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = in_range ? ST_SCAN : ST_EMIT;
            end
            ST_SCAN:
            begin
                if (last_wave.active)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            thr_reg         <= START_THRESHOLD_RST;
            out_valid_reg   <= 1'b0;
            res_verdict_reg <= 1'b0;
            res_kept_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            thr_reg         <= thr_next;
            res_verdict_reg <= res_verdict_next;
            res_kept_reg    <= res_kept_next;
            if (state_reg == ST_EMIT && out_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            len_ok_reg <= s_axis_tuser;
            port_reg   <= s_axis_tdata[15:0];
            key_reg    <= s_axis_tdata[47:16];
            frac_reg   <= s_axis_tdata[79:48];
        end
        if (state_reg == ST_SCAN && last_wave.active)
        begin
            scan_removed_reg    <= last_wave.removed;
            scan_free_found_reg <= last_wave.free_found;
            scan_top_found_reg  <= last_wave.top_found;
            scan_free_idx_reg   <= free_idx[BUFFER_ENTRIES];
            scan_top_idx_reg    <= top_idx[BUFFER_ENTRIES];
            scan_top_prio_reg   <= top_prio[BUFFER_ENTRIES];
        end
        if (state_reg == ST_EMIT && out_take)
        begin
            out_verdict_reg <= res_verdict_reg;
            out_kept_reg    <= res_kept_reg;
            out_held_reg    <= HELD_W'(count_reg);
            out_thr_reg     <= thr_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_thr_reg, out_held_reg, out_kept_reg, out_verdict_reg};

endmodule

`default_nettype wire

// ===== design/cdcs_cell.sv =====
// ---------------------------------------------------------------------------
// cdcs_cell
// One slot of the sample store plus one step of the scan chain.
// ---------------------------------------------------------------------------
`default_nettype none

module cdcs_cell #(
    parameter int unsigned IDX_W = 6,
    parameter int unsigned INDEX = 0
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  cdcs_pkg::wave_flags_t        wave_in,
    input  wire  [IDX_W-1:0]             free_idx_in,
    input  wire  [IDX_W-1:0]             top_idx_in,
    input  wire  [cdcs_pkg::PRIO_W-1:0]  top_prio_in,
    input  wire  [cdcs_pkg::KEY_W-1:0]   item_key,
    input  cdcs_pkg::cell_ctl_t          ctl,
    input  wire  [IDX_W-1:0]             wr_idx,
    input  wire  [cdcs_pkg::KEY_W-1:0]   wr_key,
    input  wire  [cdcs_pkg::PRIO_W-1:0]  wr_prio,
    output cdcs_pkg::wave_flags_t        wave_out,
    output logic [IDX_W-1:0]             free_idx_out,
    output logic [IDX_W-1:0]             top_idx_out,
    output logic [cdcs_pkg::PRIO_W-1:0]  top_prio_out
);
    import cdcs_pkg::*;

    logic              valid_reg, valid_next;
    logic [KEY_W-1:0]  key_reg;
    logic [PRIO_W-1:0] prio_reg;

    wave_flags_t       wave_reg, wave_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]  top_idx_reg, top_idx_next;
    logic [PRIO_W-1:0] top_prio_reg, top_prio_next;

    logic match;
    logic here_free;
    logic here_live;
    logic wr_hit;

    assign match     = wave_in.active && valid_reg && (key_reg == item_key);
    assign here_free = !valid_reg || match;
    assign here_live = valid_reg && !match;
    assign wr_hit    = ctl.wr_en && (wr_idx == IDX_W'(INDEX));

    always_comb
    begin
        wave_next            = wave_in;
        wave_next.removed    = wave_in.removed | match;
        free_idx_next        = free_idx_in;
        top_idx_next         = top_idx_in;
        top_prio_next        = top_prio_in;
        if (!wave_in.free_found && here_free)
        begin
            wave_next.free_found = 1'b1;
            free_idx_next        = IDX_W'(INDEX);
        end
        // strict compare keeps the lower slot on a tie
        if (here_live && (!wave_in.top_found || (prio_reg > top_prio_in)))
        begin
            wave_next.top_found = 1'b1;
            top_idx_next        = IDX_W'(INDEX);
            top_prio_next       = prio_reg;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (wr_hit)
        begin
            valid_next = 1'b1;
        end
        else if (match)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            wave_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            wave_reg  <= wave_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit && !ctl.clear)
        begin
            key_reg  <= wr_key;
            prio_reg <= wr_prio;
        end
        free_idx_reg <= free_idx_next;
        top_idx_reg  <= top_idx_next;
        top_prio_reg <= top_prio_next;
    end

    assign wave_out     = wave_reg;
    assign free_idx_out = free_idx_reg;
    assign top_idx_out  = top_idx_reg;
    assign top_prio_out = top_prio_reg;

endmodule

`default_nettype wire
